// File: rtl/hlpc_pkg.sv
// Shared types and constants for the hexagonal lattice point classifier.
// Used by every module under rtl/; no dependencies.
// Holds payload structs, register indexes and the fixed-point sqrt(3).
`timescale 1ns / 1ps
`default_nettype none
package hlpc_pkg;

	localparam int DEFAULT_FRAC_BITS = 16;

	localparam int COORD_W = 32;                // point and centre width
	localparam int REG_W   = 31;                // configuration register width
	localparam int HALF_W  = COORD_W + 1;       // doubled coordinate (half units)
	localparam int DIV_W   = 33;                // cell pitch width
	localparam int CEN_W   = 36;                // candidate centre, half units
	localparam int SQ_W    = 2 * DIV_W;         // squared distance

	// sqrt(3) with 30 fraction bits
	localparam logic [30:0] SQRT3_Q = 31'd1859775393;
	localparam int SQRT3_FRAC = 30;

	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_HOLE_DIAMETER = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SEPTA_WIDTH   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_VERTICAL_MODE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FIELD_WIDTH   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FIELD_HEIGHT  = 3'd4;

	typedef struct packed {
		logic signed [COORD_W-1:0] point_x;
		logic signed [COORD_W-1:0] point_y;
	} point_t;

	typedef struct packed {
		logic                      in_air;
		logic                      in_field;
		logic signed [COORD_W-1:0] center_x;
		logic signed [COORD_W-1:0] center_y;
	} result_t;

	// travels beside the divider
	typedef struct packed {
		logic signed [HALF_W-1:0] x;
		logic signed [HALF_W-1:0] y;
		logic                     in_field;
		logic                     pitch_zero;
	} side_t;

	// chosen centre and offsets to it
	typedef struct packed {
		logic signed [CEN_W-1:0] cx;
		logic signed [CEN_W-1:0] cy;
		logic [DIV_W-1:0]        u;
		logic [DIV_W-1:0]        v;
		logic                    in_field;
	} cand_t;

endpackage
`default_nettype wire

// File: rtl/hlpc_divmod.sv
// Pipelined restoring divider, two lanes, one quotient bit per stage.
// Depends on hlpc_pkg. Yields remainder and quotient LSB per lane.
`timescale 1ns / 1ps
`default_nettype none
module hlpc_divmod import hlpc_pkg::*; #(
	parameter int DVD_W = COORD_W
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic              in_valid,
	input  wire logic [DVD_W-1:0]  dvd_x,
	input  wire logic [DVD_W-1:0]  dvd_y,
	input  wire logic [DIV_W-1:0]  div_x,
	input  wire logic [DIV_W-1:0]  div_y,
	input  wire side_t             side_in,
	output logic                   out_valid,
	output logic [DIV_W-1:0]       rem_x,
	output logic [DIV_W-1:0]       rem_y,
	output logic                   qlsb_x,
	output logic                   qlsb_y,
	output logic [DIV_W-1:0]       div_x_out,
	output logic [DIV_W-1:0]       div_y_out,
	output side_t                  side_out
);

	logic [DVD_W:1]      vld_s;
	logic [DIV_W-1:0]    rem_x_s [1:DVD_W];
	logic [DIV_W-1:0]    rem_y_s [1:DVD_W];
	logic [DVD_W-1:0]    dvd_x_s [1:DVD_W-1];
	logic [DVD_W-1:0]    dvd_y_s [1:DVD_W-1];
	logic [DIV_W-1:0]    div_x_s [1:DVD_W];
	logic [DIV_W-1:0]    div_y_s [1:DVD_W];
	side_t               side_s  [1:DVD_W];
	logic                qlsb_x_s, qlsb_y_s;

	logic [DIV_W-1:0]    src_rx [0:DVD_W-1];
	logic [DIV_W-1:0]    src_ry [0:DVD_W-1];
	logic [DVD_W-1:0]    src_nx [0:DVD_W-1];
	logic [DVD_W-1:0]    src_ny [0:DVD_W-1];
	logic [DIV_W-1:0]    src_dx [0:DVD_W-1];
	logic [DIV_W-1:0]    src_dy [0:DVD_W-1];
	side_t               src_sd [0:DVD_W-1];
	logic [DIV_W-1:0]    nrx [0:DVD_W-1];
	logic [DIV_W-1:0]    nry [0:DVD_W-1];
	logic [DVD_W-1:0]    ge_x, ge_y;

	always_comb begin
		src_rx[0] = '0;
		src_ry[0] = '0;
		src_nx[0] = dvd_x;
		src_ny[0] = dvd_y;
		src_dx[0] = div_x;
		src_dy[0] = div_y;
		src_sd[0] = side_in;
		for (int k = 1; k < DVD_W; k++) begin
			src_rx[k] = rem_x_s[k];
			src_ry[k] = rem_y_s[k];
			src_nx[k] = dvd_x_s[k];
			src_ny[k] = dvd_y_s[k];
			src_dx[k] = div_x_s[k];
			src_dy[k] = div_y_s[k];
			src_sd[k] = side_s[k];
		end
	end

	// one trial subtract per stage
	always_comb begin
		for (int k = 0; k < DVD_W; k++) begin
			logic [DIV_W:0] tx, ty;
			tx = {src_rx[k], src_nx[k][DVD_W-1]};
			ty = {src_ry[k], src_ny[k][DVD_W-1]};
			ge_x[k] = tx >= {1'b0, src_dx[k]};
			ge_y[k] = ty >= {1'b0, src_dy[k]};
			nrx[k] = ge_x[k] ? DIV_W'(tx - {1'b0, src_dx[k]}) : tx[DIV_W-1:0];
			nry[k] = ge_y[k] ? DIV_W'(ty - {1'b0, src_dy[k]}) : ty[DIV_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[DVD_W-1:1], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < DVD_W; k++) begin
				rem_x_s[k+1] <= nrx[k];
				rem_y_s[k+1] <= nry[k];
				div_x_s[k+1] <= src_dx[k];
				div_y_s[k+1] <= src_dy[k];
				side_s[k+1]  <= src_sd[k];
			end
			for (int k = 0; k < DVD_W - 1; k++) begin
				dvd_x_s[k+1] <= src_nx[k] << 1;
				dvd_y_s[k+1] <= src_ny[k] << 1;
			end
			qlsb_x_s <= ge_x[DVD_W-1];
			qlsb_y_s <= ge_y[DVD_W-1];
		end
	end

	assign out_valid = vld_s[DVD_W];
	assign rem_x     = rem_x_s[DVD_W];
	assign rem_y     = rem_y_s[DVD_W];
	assign qlsb_x    = qlsb_x_s;
	assign qlsb_y    = qlsb_y_s;
	assign div_x_out = div_x_s[DVD_W];
	assign div_y_out = div_y_s[DVD_W];
	assign side_out  = side_s[DVD_W];

endmodule
`default_nettype wire

// File: rtl/hlpc_nearest.sv
// Nearest-centre selection: candidate corners, squared distances, compare.
// Depends on hlpc_pkg; fed by hlpc_divmod. Four pipeline stages (s3..s6).
`timescale 1ns / 1ps
`default_nettype none
module hlpc_nearest import hlpc_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             en,
	input  wire logic             in_valid,
	input  wire logic [DIV_W-1:0] rem_x,
	input  wire logic [DIV_W-1:0] rem_y,
	input  wire logic             qlsb_x,
	input  wire logic             qlsb_y,
	input  wire logic [DIV_W-1:0] w,
	input  wire logic [DIV_W-1:0] h,
	input  wire side_t            side,
	output logic                  out_valid,
	output cand_t                 cand
);

	// s3: distances to the cell corners
	logic                    flip_x, flip_y;
	logic [DIV_W-1:0]        dxa, dxb, dya, dyb;
	logic [CEN_W-1:0]        x0, y0;

	logic                    vld_s3, vld_s4, vld_s5, vld_s6;
	logic [DIV_W-1:0]        dxa_s3, dxb_s3, dya_s3, dyb_s3, w_s3, h_s3;
	logic [CEN_W-1:0]        x0_s3, y0_s3;
	logic                    even_s3;
	side_t                   side_s3;

	logic [SQ_W-1:0]         sxa_s4, sxb_s4, sya_s4, syb_s4;
	logic [DIV_W-1:0]        dxa_s4, dxb_s4, dya_s4, dyb_s4, w_s4, h_s4;
	logic [CEN_W-1:0]        x0_s4, y0_s4;
	logic                    even_s4;
	side_t                   side_s4;

	logic [SQ_W:0]           d1_s5, d2_s5;
	logic [DIV_W-1:0]        dxa_s5, dxb_s5, dya_s5, dyb_s5, w_s5, h_s5;
	logic [CEN_W-1:0]        x0_s5, y0_s5;
	logic                    even_s5;
	side_t                   side_s5;

	logic                    second;
	logic [CEN_W-1:0]        x1, y1;
	logic [DIV_W-1:0]        abs_x, abs_y;
	cand_t                   nxt, cand_s6;

	always_comb begin
		flip_x = side.x[HALF_W-1] & (rem_x != '0);
		flip_y = side.y[HALF_W-1] & (rem_y != '0);
		dxa = flip_x ? w - rem_x : rem_x;
		dxb = flip_x ? rem_x : w - rem_x;
		dya = flip_y ? h - rem_y : rem_y;
		dyb = flip_y ? rem_y : h - rem_y;
		x0 = CEN_W'(side.x) - {{(CEN_W-DIV_W){1'b0}}, dxa};
		y0 = CEN_W'(side.y) - {{(CEN_W-DIV_W){1'b0}}, dya};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s3 <= in_valid;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dxa_s3  <= dxa;
			dxb_s3  <= dxb;
			dya_s3  <= dya;
			dyb_s3  <= dyb;
			w_s3    <= w;
			h_s3    <= h;
			x0_s3   <= x0;
			y0_s3   <= y0;
			even_s3 <= ~(qlsb_x ^ flip_x ^ qlsb_y ^ flip_y);
			side_s3 <= side;
		end
	end

	// s4: squares
	always_ff @(posedge clk) begin
		if (en) begin
			sxa_s4  <= dxa_s3 * dxa_s3;
			sxb_s4  <= dxb_s3 * dxb_s3;
			sya_s4  <= dya_s3 * dya_s3;
			syb_s4  <= dyb_s3 * dyb_s3;
			dxa_s4  <= dxa_s3;
			dxb_s4  <= dxb_s3;
			dya_s4  <= dya_s3;
			dyb_s4  <= dyb_s3;
			w_s4    <= w_s3;
			h_s4    <= h_s3;
			x0_s4   <= x0_s3;
			y0_s4   <= y0_s3;
			even_s4 <= even_s3;
			side_s4 <= side_s3;
		end
	end

	// s5: candidate distance sums
	always_ff @(posedge clk) begin
		if (en) begin
			d1_s5 <= {1'b0, sxa_s4} + {1'b0, (even_s4 ? sya_s4 : syb_s4)};
			d2_s5 <= {1'b0, sxb_s4} + {1'b0, (even_s4 ? syb_s4 : sya_s4)};
			dxa_s5  <= dxa_s4;
			dxb_s5  <= dxb_s4;
			dya_s5  <= dya_s4;
			dyb_s5  <= dyb_s4;
			w_s5    <= w_s4;
			h_s5    <= h_s4;
			x0_s5   <= x0_s4;
			y0_s5   <= y0_s4;
			even_s5 <= even_s4;
			side_s5 <= side_s4;
		end
	end

	// s6: pick the nearer, tie goes to the second
	always_comb begin
		second = !(d1_s5 < d2_s5);
		x1 = x0_s5 + {{(CEN_W-DIV_W){1'b0}}, w_s5};
		y1 = y0_s5 + {{(CEN_W-DIV_W){1'b0}}, h_s5};
		abs_x = side_s5.x[HALF_W-1] ? DIV_W'(-side_s5.x) : DIV_W'(side_s5.x);
		abs_y = side_s5.y[HALF_W-1] ? DIV_W'(-side_s5.y) : DIV_W'(side_s5.y);
		nxt.in_field = side_s5.in_field;
		if (side_s5.pitch_zero) begin
			nxt.cx = '0;
			nxt.cy = '0;
			nxt.u  = abs_x;
			nxt.v  = abs_y;
		end else if (second) begin
			nxt.cx = x1;
			nxt.cy = even_s5 ? y1 : y0_s5;
			nxt.u  = dxb_s5;
			nxt.v  = even_s5 ? dyb_s5 : dya_s5;
		end else begin
			nxt.cx = x0_s5;
			nxt.cy = even_s5 ? y0_s5 : y1;
			nxt.u  = dxa_s5;
			nxt.v  = even_s5 ? dya_s5 : dyb_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cand_s6 <= nxt;
		end
	end

	assign out_valid = vld_s6;
	assign cand      = cand_s6;

endmodule
`default_nettype wire

// File: rtl/hex_lattice_point_classifier.sv
// Top level of the hexagonal lattice point classifier.
// Depends on hlpc_pkg, hlpc_divmod and hlpc_nearest.
`timescale 1ns / 1ps
`default_nettype none
// Classifies one signed fixed-point point per clock against a centred field
// rectangle and a hexagonal hole lattice. Throughput is one point per cycle
// unless the output stalls. There are 40 register stages: two front stages
// (field test, pitch multiply; pitch rounding, divider setup), 32 stages of
// the bit-per-stage long division that gives the cell index, four stages of
// nearest-centre selection, and two stages of hexagon test and output. The
// first stage loads at the edge that accepts the request, and the request
// then passes through the stages in order to the result register. The whole
// pipeline advances together; it holds only while a finished result sits in
// the output register and is not taken, so point_ready follows
// "result register empty or being taken". Configuration writes are always
// taken (cfg_ready is high) and must only be issued while the block is idle.
module hex_lattice_point_classifier import hlpc_pkg::*; #(
	parameter int COORD_FRAC_BITS = DEFAULT_FRAC_BITS
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 point_valid,
	output logic                      point_ready,
	input  wire point_t               point,
	output logic                      result_valid,
	input  wire logic                 result_ready,
	output result_t                   result,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [COORD_W-1:0]   cfg_data
);

	localparam logic [REG_W-1:0] HOLE_RST  = REG_W'(64'd1 << COORD_FRAC_BITS);
	localparam logic [REG_W-1:0] SEPTA_RST = REG_W'((64'd1 << COORD_FRAC_BITS) / 5);
	localparam logic [REG_W-1:0] FIELD_RST = REG_W'(64'd100 << COORD_FRAC_BITS);

	// configuration registers
	logic [REG_W-1:0] hole_diameter_q, septa_width_q, field_width_q, field_height_q;
	logic             vertical_mode_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hole_diameter_q <= HOLE_RST;
			septa_width_q   <= SEPTA_RST;
			vertical_mode_q <= 1'b0;
			field_width_q   <= FIELD_RST;
			field_height_q  <= FIELD_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_HOLE_DIAMETER: hole_diameter_q <= cfg_data[REG_W-1:0];
				REG_SEPTA_WIDTH:   septa_width_q   <= cfg_data[REG_W-1:0];
				REG_VERTICAL_MODE: vertical_mode_q <= cfg_data[0];
				REG_FIELD_WIDTH:   field_width_q   <= cfg_data[REG_W-1:0];
				REG_FIELD_HEIGHT:  field_height_q  <= cfg_data[REG_W-1:0];
				default: ;
			endcase
		end
	end

	// global advance: stalls only on a held result
	logic en;
	logic vld_s8;
	assign en          = ~vld_s8 | result_ready;
	assign point_ready = en;

	// pitch sum d + s, half units
	logic [COORD_W-1:0] pitch;
	assign pitch = {1'b0, hole_diameter_q} + {1'b0, septa_width_q};

	// s1: field test, double coordinates, pitch * sqrt3
	logic [COORD_W-1:0]       ax, ay;
	logic                     inf;
	logic                     vld_s1;
	logic signed [HALF_W-1:0] x_s1, y_s1;
	logic                     inf_s1, pz_s1;
	logic [62:0]              prod_s1;

	always_comb begin
		ax  = point.point_x[COORD_W-1] ? COORD_W'(-point.point_x) : point.point_x;
		ay  = point.point_y[COORD_W-1] ? COORD_W'(-point.point_y) : point.point_y;
		inf = ({ax, 1'b0} <= {2'b0, field_width_q}) &&
		      ({ay, 1'b0} <= {2'b0, field_height_q});
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1    <= {point.point_x, 1'b0};
			y_s1    <= {point.point_y, 1'b0};
			inf_s1  <= inf;
			pz_s1   <= (pitch == '0);
			prod_s1 <= pitch * SQRT3_Q;
		end
	end

	// s2: round pitch * sqrt3, orient cell, split magnitude and sign
	logic [63:0]              rnd;
	logic [DIV_W-1:0]         lpitch, wc, hc;
	logic                     vld_s2;
	logic [COORD_W-1:0]       mx_s2, my_s2;
	logic [DIV_W-1:0]         w_s2, h_s2;
	side_t                    side_s2;

	always_comb begin
		rnd    = {1'b0, prod_s1} + (64'd1 << (SQRT3_FRAC - 1));
		lpitch = rnd[SQRT3_FRAC +: DIV_W];
		wc     = vertical_mode_q ? {1'b0, pitch} : lpitch;
		hc     = vertical_mode_q ? lpitch : {1'b0, pitch};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mx_s2 <= x_s1[HALF_W-1] ? COORD_W'(-x_s1) : x_s1[COORD_W-1:0];
			my_s2 <= y_s1[HALF_W-1] ? COORD_W'(-y_s1) : y_s1[COORD_W-1:0];
			w_s2  <= wc;
			h_s2  <= hc;
			side_s2.x          <= x_s1;
			side_s2.y          <= y_s1;
			side_s2.in_field   <= inf_s1;
			side_s2.pitch_zero <= pz_s1;
		end
	end

	// cell index by long division
	logic             div_vld;
	logic [DIV_W-1:0] rem_x, rem_y, div_w, div_h;
	logic             qlsb_x, qlsb_y;
	side_t            div_side;

	hlpc_divmod #(
		.DVD_W(COORD_W)
	) u_divmod (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_s2),
		.dvd_x     (mx_s2),
		.dvd_y     (my_s2),
		.div_x     (w_s2),
		.div_y     (h_s2),
		.side_in   (side_s2),
		.out_valid (div_vld),
		.rem_x     (rem_x),
		.rem_y     (rem_y),
		.qlsb_x    (qlsb_x),
		.qlsb_y    (qlsb_y),
		.div_x_out (div_w),
		.div_y_out (div_h),
		.side_out  (div_side)
	);

	logic  near_vld;
	cand_t cand;

	hlpc_nearest u_nearest (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (div_vld),
		.rem_x     (rem_x),
		.rem_y     (rem_y),
		.qlsb_x    (qlsb_x),
		.qlsb_y    (qlsb_y),
		.w         (div_w),
		.h         (div_h),
		.side      (div_side),
		.out_valid (near_vld),
		.cand      (cand)
	);

	// s7: swap for vertical lattice, slope product, centre halving
	logic [DIV_W-1:0]          uu, vv;
	logic signed [CEN_W-1:0]   hx, hy;
	logic [COORD_W-1:0]        sat_x, sat_y;
	logic                      vld_s7;
	logic [62:0]               slope_s7;
	logic                      ult_s7, vltd_s7, inf_s7;
	logic [REG_W-1:0]          vlow_s7;
	logic [COORD_W-1:0]        cx_s7, cy_s7;

	function automatic logic [COORD_W-1:0] sat32(input logic signed [CEN_W-1:0] a);
		logic [COORD_W-1:0] r;
		if (a[CEN_W-1:COORD_W-1] == '0 || a[CEN_W-1:COORD_W-1] == '1) begin
			r = a[COORD_W-1:0];
		end else if (a[CEN_W-1]) begin
			r = {1'b1, {(COORD_W-1){1'b0}}};
		end else begin
			r = {1'b0, {(COORD_W-1){1'b1}}};
		end
		return r;
	endfunction

	always_comb begin
		uu    = vertical_mode_q ? cand.v : cand.u;
		vv    = vertical_mode_q ? cand.u : cand.v;
		hx    = cand.cx >>> 1;
		hy    = cand.cy >>> 1;
		sat_x = sat32(hx);
		sat_y = sat32(hy);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			slope_s7 <= uu[COORD_W-1:0] * SQRT3_Q;
			ult_s7   <= ~uu[DIV_W-1];
			vltd_s7  <= vv < {2'b0, hole_diameter_q};
			vlow_s7  <= vv[REG_W-1:0];
			inf_s7   <= cand.in_field;
			cx_s7    <= sat_x;
			cy_s7    <= sat_y;
		end
	end

	// s8: hexagon edge test, output register
	logic [63:0] lhs, rhs;
	result_t     res_s8;

	always_comb begin
		lhs = {1'b0, slope_s7} + {3'b0, vlow_s7, {SQRT3_FRAC{1'b0}}};
		rhs = {2'b0, hole_diameter_q, {(SQRT3_FRAC + 1){1'b0}}};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s8.in_air   <= inf_s7 & ult_s7 & vltd_s7 & (lhs < rhs);
			res_s8.in_field <= inf_s7;
			res_s8.center_x <= inf_s7 ? cx_s7 : '0;
			res_s8.center_y <= inf_s7 ? cy_s7 : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
		end else if (en) begin
			vld_s1 <= point_valid;
			vld_s2 <= vld_s1;
			vld_s7 <= near_vld;
			vld_s8 <= vld_s7;
		end
	end

	assign result_valid = vld_s8;
	assign result       = res_s8;

endmodule
`default_nettype wire

// File: rtl/hlpc_checker.sv
// Port-level checks for hex_lattice_point_classifier, bound to the top level.
// Depends on hlpc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module hlpc_checker import hlpc_pkg::*; (
	input wire logic    clk,
	input wire logic    arst_n,
	input wire logic    point_ready,
	input wire logic    result_valid,
	input wire logic    result_ready,
	input wire result_t result
);

	// held result stays put
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	// empty output never blocks new requests
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |-> point_ready)
		else $error("input blocked with empty output");

	// outside the field everything reads zero
	a_outside: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.in_field |->
			!result.in_air && result.center_x == '0 && result.center_y == '0)
		else $error("nonzero result outside field");

endmodule

bind hex_lattice_point_classifier hlpc_checker u_hlpc_checker (.*);
`default_nettype wire
